// ----- design/lbp_pkg.sv -----
// Package for the LED blink pattern player: op codes, ROM contents, shared types.
package lbp_pkg;

  localparam int unsigned RomRows = 16;
  localparam int unsigned RomCols = 16;
  localparam int unsigned RomIvW  = 16;
  localparam int unsigned LenW    = 5;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SELECT = 1'b1
  } op_e;

  // Per-row pattern info after the step-count clamp.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic            rpt;
  } rom_info_t;

  // Interval lengths in ms; rows: smart, provisioning, refactor, data receive,
  // activated, error, update entry, update leave, exit.
  localparam logic [RomIvW-1:0] RomInterval [RomRows][RomCols] = '{
    0: '{0:16'd1000, 1:16'd1000, 2:16'd1000, 3:16'd1000,
         4:16'd1000, 5:16'd1000, 6:16'd1000, 7:16'd1000, default:16'd0},
    1: '{0:16'd500, 1:16'd500, 2:16'd500, 3:16'd500,
         4:16'd500, 5:16'd500, 6:16'd500, 7:16'd500, default:16'd0},
    2: '{0:16'd100, 1:16'd100, 2:16'd100, 3:16'd100,
         4:16'd100, 5:16'd100, default:16'd0},
    3: '{0:16'd400, 1:16'd50, 2:16'd400, 3:16'd50,
         4:16'd400, 5:16'd50, default:16'd0},
    4: '{0:16'd1000, default:16'd0},
    5: '{0:16'd250, 1:16'd250, 2:16'd250, 3:16'd250,
         4:16'd250, 5:16'd250, 6:16'd250, 7:16'd250, default:16'd0},
    6: '{0:16'd200, 1:16'd200, 2:16'd200, 3:16'd200,
         4:16'd200, 5:16'd200, default:16'd0},
    7: '{0:16'd2500, 1:16'd2500, 2:16'd2500, 3:16'd2500,
         4:16'd2500, default:16'd0},
    8: '{0:16'd100, default:16'd0},
    default: '{default:16'd0}
  };

  localparam logic [LenW-1:0] RomLength [RomRows] = '{
    0:5'd8, 1:5'd8, 2:5'd6, 3:5'd6, 4:5'd1, 5:5'd8, 6:5'd6, 7:5'd5, 8:5'd1,
    default:5'd0
  };

  localparam logic RomRepeat [RomRows] = '{
    0:1'b1, 1:1'b1, 2:1'b1, 3:1'b1, 4:1'b0, 5:1'b0, 6:1'b1, 7:1'b0, 8:1'b0,
    default:1'b0
  };

endpackage

// ----- design/lbp_rom.sv -----
// Pattern ROM read port: interval with saturation, clamped length, repeat flag.
module lbp_rom #(
  parameter int unsigned MAX_STEPS     = 8,
  parameter int unsigned INTERVAL_BITS = 12
) (
  input  logic [3:0]               row_i,
  input  logic [3:0]               col_i,
  output logic [INTERVAL_BITS-1:0] interval_o,
  output lbp_pkg::rom_info_t       info_o
);
  import lbp_pkg::*;

  localparam int unsigned IvMax = (1 << INTERVAL_BITS) - 1;

  logic [RomIvW-1:0] raw;
  logic [LenW-1:0]   len_raw;

  always_comb begin
    raw        = RomInterval[row_i][col_i];
    len_raw    = RomLength[row_i];
    interval_o = (32'(raw) > IvMax) ? INTERVAL_BITS'(IvMax) : INTERVAL_BITS'(raw);
    info_o.len = (len_raw > LenW'(MAX_STEPS)) ? LenW'(MAX_STEPS) : len_raw;
    info_o.rpt = RomRepeat[row_i];
  end

endmodule

// ----- design/lbp_step.sv -----
// Next-state logic for one item: select, tick countdown, interval expiry.
module lbp_step #(
  parameter int unsigned NUM_PATTERNS  = 9,
  parameter int unsigned INTERVAL_BITS = 12
) (
  input  logic                     op_i,
  input  logic [3:0]               id_i,
  input  logic [3:0]               pat_i,
  input  logic [3:0]               step_i,
  input  logic [INTERVAL_BITS-1:0] rem_i,
  input  logic                     led_i,
  input  logic                     act_i,
  // ROM read at (id, 0), at (pat, step + 1) and at (pat, 0)
  input  logic [INTERVAL_BITS-1:0] sel_iv_i,
  input  lbp_pkg::rom_info_t       sel_info_i,
  input  logic [INTERVAL_BITS-1:0] nxt_iv_i,
  input  lbp_pkg::rom_info_t       cur_info_i,
  input  logic [INTERVAL_BITS-1:0] cur_first_iv_i,
  output logic [3:0]               pat_o,
  output logic [3:0]               step_o,
  output logic [INTERVAL_BITS-1:0] rem_o,
  output logic                     led_o,
  output logic                     act_o
);
  import lbp_pkg::*;

  logic [LenW-1:0] nxt;
  logic            known;
  logic            expired;

  always_comb begin
    pat_o   = pat_i;
    step_o  = step_i;
    rem_o   = rem_i;
    led_o   = led_i;
    act_o   = act_i;
    nxt     = {1'b0, step_i} + LenW'(1);
    known   = {1'b0, id_i} < LenW'(NUM_PATTERNS);
    expired = (rem_i[INTERVAL_BITS-1:1] == '0);
    case (op_e'(op_i))
      OP_SELECT: begin
        if (known) begin
          pat_o  = id_i;
          step_o = '0;
          if (sel_info_i.len != '0) begin
            led_o = 1'b1;
            act_o = 1'b1;
            rem_o = sel_iv_i;
          end else begin
            led_o = 1'b0;
            act_o = 1'b0;
            rem_o = '0;
          end
        end else begin
          led_o = 1'b0;
          act_o = 1'b0;
          rem_o = '0;
        end
      end
      OP_TICK: begin
        if (act_i) begin
          if (!expired) begin
            rem_o = rem_i - INTERVAL_BITS'(1);
          end else if (nxt < cur_info_i.len) begin
            led_o  = ~led_i;
            step_o = nxt[3:0];
            rem_o  = nxt_iv_i;
          end else if (cur_info_i.rpt) begin
            // restart; the row is non-empty since an interval just ran
            step_o = '0;
            led_o  = 1'b1;
            act_o  = 1'b1;
            rem_o  = cur_first_iv_i;
          end else begin
            led_o = 1'b0;
            act_o = 1'b0;
            rem_o = '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/led_blink_pattern_player.sv -----
// Each result is registered; it is valid the cycle after its item is accepted.
// Throughput: one item per cycle unless the master side stalls; the state update is
//   a ROM lookup plus a decrement between state registers and result register.
// The result register frees the input side whenever it is empty or being drained.
// Reset: asynchronous, active low; LED off, idle, pattern 0, no result pending.
module led_blink_pattern_player #(
  parameter int unsigned MAX_STEPS     = 8,
  parameter int unsigned NUM_PATTERNS  = 9,
  parameter int unsigned INTERVAL_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [3:0] pattern_id, [7:4] zero
  input  logic [0:0] s_axis_tuser_i,   // [0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] led_on, [1] playing, [7:2] zero
);
  import lbp_pkg::*;

  logic [3:0]               pat_q, pat_d;
  logic [3:0]               step_q, step_d;
  logic [INTERVAL_BITS-1:0] rem_q, rem_d;
  logic                     led_q, led_d;
  logic                     act_q, act_d;
  logic                     out_valid_q;
  logic [1:0]               out_data_q;

  logic                     accept;
  logic [INTERVAL_BITS-1:0] sel_iv, nxt_iv, first_iv;
  rom_info_t                sel_info, cur_info, first_info;
  logic [3:0]               nxt_col;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign nxt_col         = step_q + 4'd1;

  lbp_rom #(.MAX_STEPS(MAX_STEPS), .INTERVAL_BITS(INTERVAL_BITS)) u_rom_sel (
    .row_i(s_axis_tdata_i[3:0]), .col_i(4'd0), .interval_o(sel_iv), .info_o(sel_info)
  );

  lbp_rom #(.MAX_STEPS(MAX_STEPS), .INTERVAL_BITS(INTERVAL_BITS)) u_rom_nxt (
    .row_i(pat_q), .col_i(nxt_col), .interval_o(nxt_iv), .info_o(cur_info)
  );

  lbp_rom #(.MAX_STEPS(MAX_STEPS), .INTERVAL_BITS(INTERVAL_BITS)) u_rom_first (
    .row_i(pat_q), .col_i(4'd0), .interval_o(first_iv), .info_o(first_info)
  );

  lbp_step #(.NUM_PATTERNS(NUM_PATTERNS), .INTERVAL_BITS(INTERVAL_BITS)) u_step (
    .op_i           (s_axis_tuser_i[0]),
    .id_i           (s_axis_tdata_i[3:0]),
    .pat_i          (pat_q),
    .step_i         (step_q),
    .rem_i          (rem_q),
    .led_i          (led_q),
    .act_i          (act_q),
    .sel_iv_i       (sel_iv),
    .sel_info_i     (sel_info),
    .nxt_iv_i       (nxt_iv),
    .cur_info_i     (cur_info),
    .cur_first_iv_i (first_info.len != '0 ? first_iv : '0),
    .pat_o          (pat_d),
    .step_o         (step_d),
    .rem_o          (rem_d),
    .led_o          (led_d),
    .act_o          (act_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      step_q <= '0;
      rem_q  <= '0;
      led_q  <= 1'b0;
      act_q  <= 1'b0;
    end else if (accept) begin
      pat_q  <= pat_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      led_q  <= led_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {act_d, led_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_data_q};

endmodule

// ----- design/lbp_checker.sv -----
// Port-level checks for the LED blink pattern player, bound to the top level.
module lbp_checker #(
  parameter int unsigned NUM_PATTERNS = 9
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic [0:0] s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);
  import lbp_pkg::*;

  logic in_acc;
  logic unknown_sel;

  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign unknown_sel = (s_axis_tuser_i[0] == OP_SELECT) &&
                       ({1'b0, s_axis_tdata_i[3:0]} >= 5'(NUM_PATTERNS));

  // a result only follows an accepted item
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc))
    else $error("result without an accepted item");

  // lit LED only while an interval is timed
  a_led_implies_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("LED lit while idle");

  // unknown id stops playback with LED off
  a_unknown_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && unknown_sel) |=> (m_axis_tvalid_o && m_axis_tdata_o[1:0] == 2'b00))
    else $error("unknown id did not stop playback");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // empty output stage always takes an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

endmodule

bind led_blink_pattern_player lbp_checker #(.NUM_PATTERNS(NUM_PATTERNS)) u_lbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- bench/testbench.sv -----
// Self-checking bench for the LED blink pattern player: random streams, inline predictor.
`timescale 1ns / 1ps

module testbench;
  import lbp_pkg::*;

  localparam int unsigned MaxSteps    = 8;
  localparam int unsigned NumPatterns = 9;
  localparam int unsigned IvBits      = 12;
  localparam logic [IvBits-1:0] IvMax = {IvBits{1'b1}};
  localparam int unsigned TargetItems = 1550;
  localparam int unsigned MaxPrints   = 100;

  typedef struct packed {
    op_e        op;
    logic [3:0] id;
  } blink_cmd_t;

  // bit 0 matches led_on in tdata, bit 1 playing
  typedef struct packed {
    logic playing;
    logic led_on;
  } lamp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_tdata = 8'd0;
  logic [0:0] s_tuser = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_tdata;

  blink_cmd_t cmd_q[$];
  lamp_t      lamp_q[$];
  int         n_made = 0;
  int         n_taken = 0;
  int         n_errors = 0;
  logic       in_taken = 1'b0;
  logic       calm = 1'b0;
  int         calm_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  logic       hold_off = 1'b0;

  // predictor state
  logic [3:0]        cur_pat = '0;
  logic [3:0]        step_idx = '0;
  logic [IvBits-1:0] ms_left = '0;
  logic              led_lvl = 1'b0;
  logic              is_active = 1'b0;

  led_blink_pattern_player #(
    .MAX_STEPS    (MaxSteps),
    .NUM_PATTERNS (NumPatterns),
    .INTERVAL_BITS(IvBits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),   // [3:0] pattern_id, [7:4] zero
    .s_axis_tuser_i (s_tuser),   // [0] op
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata)    // [0] led_on, [1] playing, [7:2] zero
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] steps_of(logic [3:0] p);
    logic [4:0] n;
    n = RomLength[p];
    return (n > MaxSteps) ? 5'(MaxSteps) : n;
  endfunction

  function automatic logic [IvBits-1:0] ms_of(logic [3:0] p, logic [4:0] i);
    logic [RomIvW-1:0] v;
    v = RomInterval[p][i[3:0]];
    return (v > IvMax) ? IvMax : v[IvBits-1:0];
  endfunction

  task automatic restart_pattern();
    led_lvl   = 1'b0;
    is_active = 1'b0;
    step_idx  = '0;
    ms_left   = '0;
    if (steps_of(cur_pat) > 0) begin
      led_lvl   = 1'b1;
      is_active = 1'b1;
      ms_left   = ms_of(cur_pat, 5'd0);
    end
  endtask

  task automatic interval_done();
    logic [4:0] nxt;
    nxt = {1'b0, step_idx} + 5'd1;
    if (nxt < steps_of(cur_pat)) begin
      led_lvl  = ~led_lvl;
      step_idx = nxt[3:0];
      ms_left  = ms_of(cur_pat, nxt);
    end else if (RomRepeat[cur_pat]) begin
      restart_pattern();
    end else begin
      led_lvl   = 1'b0;
      is_active = 1'b0;
      ms_left   = '0;
    end
  endtask

  // Advance the player by one item and queue the lamp state it leaves behind.
  task automatic advance_player(op_e op, logic [3:0] id);
    if (op == OP_SELECT) begin
      if (id < NumPatterns) begin
        cur_pat = id;
        restart_pattern();
      end else begin
        led_lvl   = 1'b0;
        is_active = 1'b0;
        ms_left   = '0;
      end
    end else if (is_active) begin
      if (ms_left <= 1) begin
        ms_left = '0;
        interval_done();
      end else begin
        ms_left = ms_left - 1'b1;
      end
    end
    lamp_q.push_back('{playing: is_active, led_on: led_lvl});
  endtask

  task automatic report_mismatch(string what);
    if (n_errors < MaxPrints) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    n_errors++;
  endtask

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap(logic quiet);
    if (quiet || $urandom_range(0, 3) != 0) begin
      return 0;
    end
    return ($urandom_range(0, 7) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  task automatic add_item(op_e op, logic [3:0] id);
    cmd_q.push_back('{op: op, id: id});
    n_made++;
  endtask

  // tick items carry random ids; the block must ignore them
  task automatic add_ticks(int n);
    for (int k = 0; k < n; k++) begin
      add_item(OP_TICK, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic add_short_run();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      if ($urandom_range(0, 9) < 7) begin
        add_item(OP_SELECT, 4'($urandom_range(0, NumPatterns - 1)));
      end else begin
        add_item(OP_SELECT, 4'($urandom_range(NumPatterns, 15)));
      end
      add_ticks($urandom_range(0, 25));
    end else if (r <= 7) begin
      add_ticks($urandom_range(1, 8));
    end else begin
      add_item(OP_SELECT, 4'($urandom_range(NumPatterns, 15)));
      add_ticks($urandom_range(0, 3));
    end
  endtask

  // Runs long enough to reach interval ends: single-shot stop, toggle, repeat.
  task automatic add_long_play(int which);
    case (which)
      0: begin
        add_item(OP_SELECT, 4'd8);
        add_ticks($urandom_range(95, 105));
      end
      1: begin
        add_item(OP_SELECT, 4'd3);
        add_ticks($urandom_range(440, 470));
      end
      default: begin
        add_item(OP_SELECT, 4'd2);
        add_ticks($urandom_range(598, 640));
      end
    endcase
  endtask

  // input side: predictor runs on every accepted item
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) begin
      advance_player(op_e'(s_tuser[0]), s_tdata[3:0]);
      cmd_q.delete(0);
      n_taken++;
    end
  end

  // output side
  always @(posedge clk_i) begin
    lamp_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (lamp_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no item pending", m_tdata));
      end else begin
        want = lamp_q[0];
        lamp_q.delete(0);
        if (m_tdata[0] !== want.led_on) begin
          report_mismatch($sformatf("led_on %b, want %b", m_tdata[0], want.led_on));
        end
        if (m_tdata[1] !== want.playing) begin
          report_mismatch($sformatf("playing %b, want %b", m_tdata[1], want.playing));
        end
        if (m_tdata[7:2] !== 6'd0) begin
          report_mismatch($sformatf("pad bits 0x%02h not zero", m_tdata[7:2]));
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (calm_left == 0) begin
        calm      <= ($urandom_range(0, 3) == 0);
        calm_left <= $urandom_range(50, 300);
      end else begin
        calm_left <= calm_left - 1;
      end
      if (s_valid && !in_taken) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        s_valid  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() > 0) begin
        s_valid  <= 1'b1;
        s_tdata  <= {4'd0, cmd_q[0].id};
        s_tuser  <= cmd_q[0].op;
        gap_left <= pick_gap(calm);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      m_ready <= 1'b0;
    end else if (stall_left > 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_ready    <= 1'b1;
      stall_left <= pick_gap(calm);
    end
  end

  // long receiver hold-off while items keep coming
  initial begin
    while (n_taken < 400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("FAIL led_blink_pattern_player");
    $finish;
  end

  initial begin
    int order [3];
    int j;
    int t;

    // directed: idle ticks, every pattern, restart while playing, unknown ids
    add_item(OP_TICK, 4'd0);
    add_item(OP_TICK, 4'd15);
    add_item(OP_SELECT, 4'd4);
    add_item(OP_TICK, 4'd0);
    add_item(OP_SELECT, 4'd0);
    add_item(OP_TICK, 4'd7);
    add_item(OP_SELECT, 4'd1);
    add_item(OP_SELECT, 4'd2);
    add_item(OP_SELECT, 4'd3);
    add_item(OP_TICK, 4'd8);
    add_item(OP_SELECT, 4'd5);
    add_item(OP_SELECT, 4'd6);
    add_item(OP_SELECT, 4'd7);
    add_item(OP_TICK, 4'd0);
    add_item(OP_SELECT, 4'd8);
    add_item(OP_TICK, 4'd0);
    add_item(OP_SELECT, 4'd9);
    add_item(OP_TICK, 4'd0);
    add_item(OP_SELECT, 4'd15);
    add_item(OP_TICK, 4'd9);
    add_item(OP_SELECT, 4'd3);
    add_item(OP_SELECT, 4'd12);
    add_item(OP_SELECT, 4'd0);
    add_item(OP_TICK, 4'd5);

    // random: the three long plays in random order among short runs
    order = '{0, 1, 2};
    for (int k = 2; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < 3; k++) begin
      repeat ($urandom_range(3, 6)) add_short_run();
      add_long_play(order[k]);
    end
    while (n_made < TargetItems) add_short_run();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || lamp_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("PASS led_blink_pattern_player");
    end else begin
      $display("FAIL led_blink_pattern_player");
    end
    $finish;
  end

endmodule
